// ----- rtl/wrts_pkg.sv -----
// Shared types and constants for the weighted random timed sequencer.
// Used by wrts_mod_unit and weighted_random_timed_sequencer; no dependencies.
`default_nettype none

package wrts_pkg;

    localparam int NUM_MODES  = 6;
    localparam int SPEC_COUNT = 6;
    localparam int SPEC_W     = 42;
    localparam int DRIVE_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int SUM_W      = $clog2(NUM_MODES * 255 + 1);
    localparam int DRAW_W     = 16;
    localparam int DIVISOR_W  = DRAW_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 3'd6;

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_STOP   = 3'd2;
    localparam logic [2:0] FUNC_PAUSE  = 3'd3;
    localparam logic [2:0] FUNC_RESUME = 3'd4;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SETTLE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CENTER  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COAST   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BRAKE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd5;

    localparam logic [1:0] DRIVE_COAST   = 2'd0;
    localparam logic [1:0] DRIVE_BRAKE   = 2'd1;
    localparam logic [1:0] DRIVE_REVERSE = 2'd2;

    localparam logic [SPEC_W-1:0] SPEC_RESET [SPEC_COUNT] = '{
        42'd20132761606,
        42'd4026542085,
        42'd6710896653,
        42'd134217779207,
        42'd12079636487,
        42'd6710896649
    };
    localparam logic [DRIVE_W-1:0] DRIVE_RESET = 17'd106516;

    typedef struct packed {
        logic                 start;
        logic [DRAW_W-1:0]    dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DRAW_W-1:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/wrts_mod_unit.sv -----
// Shared restoring remainder unit: 16-bit dividend modulo a 17-bit divisor,
// one quotient bit per cycle. Depends on wrts_pkg.
`default_nettype none

module wrts_mod_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wrts_pkg::div_req_t req,
    output wrts_pkg::div_rsp_t     rsp
);

    localparam int CNT_W = $clog2(wrts_pkg::DRAW_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [wrts_pkg::DRAW_W-1:0]    shift_reg, shift_next;
    logic [wrts_pkg::DRAW_W-1:0]    rem_reg, rem_next;
    logic [wrts_pkg::DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [wrts_pkg::DIVISOR_W-1:0] trial;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        trial        = {rem_reg, shift_reg[wrts_pkg::DRAW_W-1]};
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(wrts_pkg::DRAW_W - 1);
            shift_next   = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= divisor_reg)
            begin
                rem_next = wrts_pkg::DRAW_W'(trial - divisor_reg);
            end
            else
            begin
                rem_next = trial[wrts_pkg::DRAW_W-1:0];
            end
            shift_next = {shift_reg[wrts_pkg::DRAW_W-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/weighted_random_timed_sequencer.sv -----
// Top level of the weighted random timed sequencer; depends on wrts_pkg and wrts_mod_unit.
// A result is loaded in ST_OUT, entered straight from the beat for stop, pause, resume,
// unused codes and a tick that ends no mode; a start or an expiry without random selection
// first takes one 16-step remainder pass, a random expiry up to two and two mode scans.
// The next beat is accepted once a result is loaded, which waits while the output stalls.
// Reset loads the register defaults and clears the FSM and mode state, not draws or m_tdata.
`default_nettype none

module weighted_random_timed_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] pick_draw, [31:16] dur_draw
    input  wire logic [2:0]  s_tuser,   // [2:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [2:0] mode_now, [10:3] drive_level,
                                        // [11] center_active, [12] flicker_active,
                                        // [13] is_running, [14] is_paused,
                                        // [15] mode_entered, [31:16] duration_ms
    output logic [1:0]       m_tuser,   // [1:0] drive_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [41:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_PICK_DIV,
        ST_PICK_SCAN,
        ST_DUR_START,
        ST_DUR_DIV,
        ST_OUT
    } state_t;

    localparam int MW = wrts_pkg::MODE_W;
    localparam int IW = wrts_pkg::IDX_W;
    localparam int SW = wrts_pkg::SUM_W;
    localparam int DW = wrts_pkg::DRAW_W;

    logic [wrts_pkg::SPEC_W-1:0]  spec_reg [wrts_pkg::SPEC_COUNT];
    logic [wrts_pkg::DRIVE_W-1:0] drive_reg;

    state_t         state_reg, state_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [SW-1:0]  acc_reg, acc_next;
    logic [SW-1:0]  total_reg, total_next;
    logic [DW-1:0]  pick_reg, pick_next;
    logic [DW-1:0]  pdraw_reg, pdraw_next;
    logic [DW-1:0]  ddraw_reg, ddraw_next;
    logic [DW-1:0]  lo_reg, lo_next;
    logic [MW-1:0]  mode_reg, mode_next;
    logic           run_reg, run_next;
    logic           pause_reg, pause_next;
    logic [DW-1:0]  elapsed_reg, elapsed_next;
    logic [DW-1:0]  dur_reg, dur_next;
    logic [1:0]     kind_reg, kind_next;
    logic [7:0]     level_reg, level_next;
    logic           center_reg, center_next;
    logic           flicker_reg, flicker_next;
    logic           entered_reg, entered_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [31:0]    m_tdata_reg, m_tdata_next;
    logic [1:0]     m_tuser_reg, m_tuser_next;

    logic [wrts_pkg::SPEC_W-1:0] cur_spec;
    logic                        elig;
    logic [SW-1:0]               acc_sum;
    logic [DW-1:0]               spec_min, spec_max, lo_val, hi_val, elapsed_inc;
    logic                        last_idx;
    logic [MW-1:0]               enter_mode;
    wrts_pkg::div_req_t          div_req;
    wrts_pkg::div_rsp_t          div_rsp;

    wrts_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wrts_pkg::SPEC_COUNT; i++)
            begin
                spec_reg[i] <= wrts_pkg::SPEC_RESET[i];
            end
            drive_reg <= wrts_pkg::DRIVE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index < wrts_pkg::CFG_IDX_W'(wrts_pkg::SPEC_COUNT))
            begin
                spec_reg[cfg_index] <= cfg_data;
            end
            else if (cfg_index == wrts_pkg::CFG_DRIVE)
            begin
                drive_reg <= cfg_data[wrts_pkg::DRIVE_W-1:0];
            end
        end
    end

    assign cur_spec    = spec_reg[idx_reg];
    assign elig        = cur_spec[0] && !((MW'(idx_reg) == mode_reg) && !cur_spec[1]);
    assign acc_sum     = acc_reg + (elig ? SW'(cur_spec[9:2]) : SW'(0));
    assign spec_min    = cur_spec[25:10];
    assign spec_max    = cur_spec[41:26];
    assign lo_val      = (spec_min > spec_max) ? spec_max : spec_min;
    assign hi_val      = (spec_min > spec_max) ? spec_min : spec_max;
    assign last_idx    = (idx_reg == IW'(wrts_pkg::NUM_MODES - 1));
    assign elapsed_inc = (elapsed_reg != {DW{1'b1}}) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign enter_mode  = MW'(idx_reg);
    assign s_tready    = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        total_next    = total_reg;
        pick_next     = pick_reg;
        pdraw_next    = pdraw_reg;
        ddraw_next    = ddraw_reg;
        lo_next       = lo_reg;
        mode_next     = mode_reg;
        run_next      = run_reg;
        pause_next    = pause_reg;
        elapsed_next  = elapsed_reg;
        dur_next      = dur_reg;
        kind_next     = kind_reg;
        level_next    = level_reg;
        center_next   = center_reg;
        flicker_next  = flicker_reg;
        entered_next  = entered_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_req.start    = 1'b0;
        div_req.dividend = pdraw_reg;
        div_req.divisor  = wrts_pkg::DIVISOR_W'(total_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pdraw_next   = s_tdata[15:0];
                    ddraw_next   = s_tdata[31:16];
                    entered_next = 1'b0;
                    state_next   = ST_OUT;
                    case (s_tuser)
                        wrts_pkg::FUNC_TICK:
                        begin
                            if (run_reg && !pause_reg)
                            begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= dur_reg)
                                begin
                                    entered_next = 1'b1;
                                    if (drive_reg[16])
                                    begin
                                        idx_next   = '0;
                                        acc_next   = '0;
                                        state_next = ST_TOTAL;
                                    end
                                    else
                                    begin
                                        idx_next   = IW'(mode_reg);
                                        state_next = ST_DUR_START;
                                    end
                                end
                            end
                        end
                        wrts_pkg::FUNC_START:
                        begin
                            run_next     = 1'b1;
                            pause_next   = 1'b0;
                            entered_next = 1'b1;
                            idx_next     = IW'(wrts_pkg::MODE_SETTLE);
                            state_next   = ST_DUR_START;
                        end
                        wrts_pkg::FUNC_STOP:
                        begin
                            run_next    = 1'b0;
                            pause_next  = 1'b0;
                            center_next = 1'b0;
                            kind_next   = wrts_pkg::DRIVE_COAST;
                            level_next  = '0;
                            mode_next   = wrts_pkg::MODE_IDLE;
                        end
                        wrts_pkg::FUNC_PAUSE:
                        begin
                            pause_next = 1'b1;
                        end
                        wrts_pkg::FUNC_RESUME:
                        begin
                            pause_next   = 1'b0;
                            elapsed_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TOTAL:
            begin
                acc_next = acc_sum;
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    total_next = acc_sum;
                    acc_next   = '0;
                    if (acc_sum == '0)
                    begin
                        idx_next   = IW'(mode_reg);
                        state_next = ST_DUR_START;
                    end
                    else
                    begin
                        idx_next         = '0;
                        div_req.start    = 1'b1;
                        div_req.divisor  = wrts_pkg::DIVISOR_W'(acc_sum);
                        state_next       = ST_PICK_DIV;
                    end
                end
            end
            ST_PICK_DIV:
            begin
                if (div_rsp.done)
                begin
                    pick_next  = div_rsp.rem;
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = ST_PICK_SCAN;
                end
            end
            ST_PICK_SCAN:
            begin
                acc_next = acc_sum;
                if (elig && (pick_reg < DW'(acc_sum)))
                begin
                    state_next = ST_DUR_START;
                end
                else if (last_idx)
                begin
                    idx_next   = IW'(mode_reg);
                    state_next = ST_DUR_START;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DUR_START:
            begin
                lo_next          = lo_val;
                div_req.start    = 1'b1;
                div_req.dividend = ddraw_reg;
                div_req.divisor  = {1'b0, hi_val} - {1'b0, lo_val} + 1'b1;
                state_next       = ST_DUR_DIV;
            end
            ST_DUR_DIV:
            begin
                if (div_rsp.done)
                begin
                    mode_next    = enter_mode;
                    elapsed_next = '0;
                    dur_next     = lo_reg + div_rsp.rem;
                    center_next  = 1'b0;
                    flicker_next = 1'b0;
                    case (enter_mode)
                        wrts_pkg::MODE_CENTER:
                        begin
                            center_next  = 1'b1;
                            flicker_next = 1'b1;
                        end
                        wrts_pkg::MODE_BRAKE:
                        begin
                            kind_next  = wrts_pkg::DRIVE_BRAKE;
                            level_next = drive_reg[15:8];
                        end
                        wrts_pkg::MODE_REVERSE:
                        begin
                            kind_next    = wrts_pkg::DRIVE_REVERSE;
                            level_next   = drive_reg[7:0];
                            flicker_next = 1'b1;
                        end
                        default:
                        begin
                            kind_next  = wrts_pkg::DRIVE_COAST;
                            level_next = '0;
                        end
                    endcase
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {dur_reg, entered_reg, pause_reg, run_reg,
                                     flicker_reg, center_reg, level_reg, mode_reg};
                    m_tuser_next  = kind_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            acc_reg      <= '0;
            total_reg    <= '0;
            mode_reg     <= wrts_pkg::MODE_IDLE;
            run_reg      <= 1'b0;
            pause_reg    <= 1'b0;
            elapsed_reg  <= '0;
            dur_reg      <= '0;
            kind_reg     <= wrts_pkg::DRIVE_COAST;
            level_reg    <= '0;
            center_reg   <= 1'b0;
            flicker_reg  <= 1'b0;
            entered_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            acc_reg      <= acc_next;
            total_reg    <= total_next;
            mode_reg     <= mode_next;
            run_reg      <= run_next;
            pause_reg    <= pause_next;
            elapsed_reg  <= elapsed_next;
            dur_reg      <= dur_next;
            kind_reg     <= kind_next;
            level_reg    <= level_next;
            center_reg   <= center_next;
            flicker_reg  <= flicker_next;
            entered_reg  <= entered_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg    <= pick_next;
        pdraw_reg   <= pdraw_next;
        ddraw_reg   <= ddraw_next;
        lo_reg      <= lo_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- sim/wrts_mode_checker.sv -----
`timescale 1ns / 1ps
// Checker for weighted_random_timed_sequencer: follows register writes, predicts the
// status beat for every accepted input beat and compares it with the output beats.
// Depends on wrts_pkg only.
module wrts_mode_checker
    import wrts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] pick_draw, [31:16] dur_draw
    input  wire logic [2:0]  s_tuser,   // [2:0] func
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [2:0] mode_now, [10:3] drive_level,
                                        // [11] center_active, [12] flicker_active,
                                        // [13] is_running, [14] is_paused,
                                        // [15] mode_entered, [31:16] duration_ms
    input  wire logic [1:0]  m_tuser,   // [1:0] drive_kind
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [41:0] cfg_data,
    output int unsigned      failures,
    output int unsigned      results_seen,
    output int unsigned      outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [MODE_W-1:0] mode_now;
        logic [1:0]        drive_kind;
        logic [7:0]        drive_level;
        logic              center_active;
        logic              flicker_active;
        logic              is_running;
        logic              is_paused;
        logic              mode_entered;
        logic [15:0]       duration_ms;
    } mode_status_t;

    logic [SPEC_W-1:0]  mode_spec [SPEC_COUNT];
    logic [DRIVE_W-1:0] drive_cfg;
    logic [MODE_W-1:0]  mode_q;
    logic               running_q;
    logic               paused_q;
    logic               center_q;
    logic               flicker_q;
    logic [15:0]        elapsed_q;
    logic [15:0]        duration_q;
    logic [1:0]         kind_q;
    logic [7:0]         level_q;
    mode_status_t       expected_status [$];

    function automatic logic mode_eligible(input int idx, input logic [MODE_W-1:0] cur);
        return mode_spec[idx][0] && !(idx == cur && !mode_spec[idx][1]);
    endfunction

    function automatic logic [MODE_W-1:0] roulette_pick(input logic [MODE_W-1:0] cur,
                                                        input logic [15:0] draw);
        int unsigned total;
        int unsigned acc;
        int unsigned point;
        total = 0;
        acc = 0;
        for (int i = 0; i < NUM_MODES && i < SPEC_COUNT; i++)
            if (mode_eligible(i, cur))
                total += mode_spec[i][9:2];
        if (total == 0)
            return cur;
        point = draw % total + 1;
        for (int i = 0; i < NUM_MODES && i < SPEC_COUNT; i++)
        begin
            if (mode_eligible(i, cur))
            begin
                acc += mode_spec[i][9:2];
                if (point <= acc)
                    return MODE_W'(i);
            end
        end
        return cur;
    endfunction

    function automatic void take_mode(input logic [MODE_W-1:0] m, input logic [15:0] draw);
        int unsigned lo;
        int unsigned hi;
        int unsigned swap;
        lo = mode_spec[m][25:10];
        hi = mode_spec[m][41:26];
        if (lo > hi)
        begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        mode_q = m;
        elapsed_q = '0;
        duration_q = 16'(lo + draw % (hi - lo + 1));
        center_q = 1'b0;
        flicker_q = 1'b0;
        case (m)
            MODE_CENTER:
            begin
                center_q = 1'b1;
                flicker_q = 1'b1;
            end
            MODE_BRAKE:
            begin
                kind_q = DRIVE_BRAKE;
                level_q = drive_cfg[15:8];
            end
            MODE_REVERSE:
            begin
                kind_q = DRIVE_REVERSE;
                level_q = drive_cfg[7:0];
                flicker_q = 1'b1;
            end
            default:
            begin
                kind_q = DRIVE_COAST;
                level_q = '0;
            end
        endcase
    endfunction

    function automatic mode_status_t predict_status(input logic [2:0] func,
                                                    input logic [15:0] pick_draw,
                                                    input logic [15:0] dur_draw);
        logic              entered;
        logic [MODE_W-1:0] next_mode;
        entered = 1'b0;
        case (func)
            FUNC_TICK:
            begin
                if (running_q && !paused_q)
                begin
                    if (elapsed_q != 16'hFFFF)
                        elapsed_q++;
                    if (elapsed_q >= duration_q)
                    begin
                        next_mode = drive_cfg[16] ? roulette_pick(mode_q, pick_draw) : mode_q;
                        take_mode(next_mode, dur_draw);
                        entered = 1'b1;
                    end
                end
            end
            FUNC_START:
            begin
                running_q = 1'b1;
                paused_q = 1'b0;
                take_mode(MODE_SETTLE, dur_draw);
                entered = 1'b1;
            end
            FUNC_STOP:
            begin
                running_q = 1'b0;
                paused_q = 1'b0;
                center_q = 1'b0;
                kind_q = DRIVE_COAST;
                level_q = '0;
                mode_q = MODE_IDLE;
            end
            FUNC_PAUSE:
                paused_q = 1'b1;
            FUNC_RESUME:
            begin
                paused_q = 1'b0;
                elapsed_q = '0;
            end
            default: ;
        endcase
        return '{mode_now: mode_q, drive_kind: kind_q, drive_level: level_q,
                 center_active: center_q, flicker_active: flicker_q,
                 is_running: running_q, is_paused: paused_q,
                 mode_entered: entered, duration_ms: duration_q};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mode_status_t got;
        mode_status_t want;
        string        bad;
        if (!rst_n)
        begin
            for (int i = 0; i < SPEC_COUNT; i++)
                mode_spec[i] = SPEC_RESET[i];
            drive_cfg = DRIVE_RESET;
            mode_q = MODE_IDLE;
            running_q = 1'b0;
            paused_q = 1'b0;
            center_q = 1'b0;
            flicker_q = 1'b0;
            elapsed_q = '0;
            duration_q = '0;
            kind_q = DRIVE_COAST;
            level_q = '0;
            expected_status.delete();
            failures <= 0;
            results_seen <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < SPEC_COUNT)
                    mode_spec[cfg_index] = cfg_data;
                else if (cfg_index == CFG_DRIVE)
                    drive_cfg = cfg_data[DRIVE_W-1:0];
            end
            if (s_tvalid && s_tready)
                expected_status.push_back(predict_status(s_tuser, s_tdata[15:0],
                                                         s_tdata[31:16]));
            if (m_tvalid && m_tready)
            begin
                got = '{mode_now: m_tdata[2:0], drive_kind: m_tuser,
                        drive_level: m_tdata[10:3], center_active: m_tdata[11],
                        flicker_active: m_tdata[12], is_running: m_tdata[13],
                        is_paused: m_tdata[14], mode_entered: m_tdata[15],
                        duration_ms: m_tdata[31:16]};
                results_seen <= results_seen + 1;
                if (expected_status.size() == 0)
                begin
                    if (failures < REPORT_LIMIT)
                        $display("unexpected status beat: actual %p", got);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_status.pop_front();
                    bad = "";
                    if (got.mode_now != want.mode_now)
                        bad = {bad, " mode_now"};
                    if (got.drive_kind != want.drive_kind)
                        bad = {bad, " drive_kind"};
                    if (got.drive_level != want.drive_level)
                        bad = {bad, " drive_level"};
                    if (got.center_active != want.center_active)
                        bad = {bad, " center_active"};
                    if (got.flicker_active != want.flicker_active)
                        bad = {bad, " flicker_active"};
                    if (got.is_running != want.is_running)
                        bad = {bad, " is_running"};
                    if (got.is_paused != want.is_paused)
                        bad = {bad, " is_paused"};
                    if (got.mode_entered != want.mode_entered)
                        bad = {bad, " mode_entered"};
                    if (got.duration_ms != want.duration_ms)
                        bad = {bad, " duration_ms"};
                    if (bad != "")
                    begin
                        if (failures < REPORT_LIMIT)
                            $display("status mismatch in%s: expected %p, actual %p",
                                     bad, want, got);
                        failures <= failures + 1;
                    end
                end
            end
            outstanding <= expected_status.size();
        end
    end

endmodule

// ----- sim/weighted_random_timed_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for weighted_random_timed_sequencer: clock, reset, input and register
// stimulus with random idling on both sides, and the verdict.
// Depends on wrts_pkg, the block's RTL and wrts_mode_checker.
module weighted_random_timed_sequencer_tb;
    import wrts_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int CFG_SLOTS    = 8;
    localparam int DRAIN_CYCLES = 100;

    typedef enum int {SET_SHUFFLED, SET_EXTREME, SET_NO_WEIGHT, SET_NO_RANDOM} reg_set_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = FUNC_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [41:0] cfg_data = '0;

    int unsigned failures;
    int unsigned results_seen;
    int unsigned outstanding;
    int unsigned beats_sent = 0;
    int unsigned tx_idle_pct = 34;
    int unsigned rx_idle_pct = 51;
    logic [SPEC_W-1:0] reg_plan [CFG_SLOTS];

    weighted_random_timed_sequencer DUT (.*);

    wrts_mode_checker checker_inst (.*);

    always #10 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [SPEC_W-1:0] make_spec(input logic en, input logic rep,
                                                    input logic [7:0] weight,
                                                    input logic [15:0] min_ms,
                                                    input logic [15:0] max_ms);
        return {max_ms, min_ms, weight, rep, en};
    endfunction

    function automatic logic [SPEC_W-1:0] random_spec();
        logic [7:0]  weight;
        logic [15:0] max_ms;
        weight = ($urandom_range(7, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
        max_ms = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(40, 0))
                                             : 16'($urandom_range(12, 0));
        return make_spec($urandom_range(9, 0) != 0, 1'($urandom), weight,
                         16'($urandom_range(6, 0)), max_ms);
    endfunction

    function automatic logic [15:0] random_draw();
        int unsigned roll;
        roll = $urandom_range(15, 0);
        if (roll == 0)
            return 16'h0000;
        if (roll == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic send_beat(input logic [2:0] func, input logic [15:0] pick_draw,
                             input logic [15:0] dur_draw);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {dur_draw, pick_draw};
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_random_beat(output bit counted);
        int unsigned roll;
        logic [2:0]  func;
        roll = $urandom_range(99, 0);
        if (roll < 4)
            func = FUNC_START;
        else if (roll < 7)
            func = FUNC_STOP;
        else if (roll < 11)
            func = FUNC_PAUSE;
        else if (roll < 16)
            func = FUNC_RESUME;
        else if (roll < 18)
            func = 3'(FUNC_RESUME + $urandom_range(3, 1));
        else
            func = FUNC_TICK;
        counted = (func <= FUNC_RESUME);
        send_beat(func, random_draw(), random_draw());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_seen < beats_sent)
            @(posedge clk);
    endtask

    task automatic write_registers();
        for (int idx = 0; idx < CFG_SLOTS; idx++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(idx);
            cfg_data <= reg_plan[idx];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic plan_registers(input reg_set_t kind);
        for (int i = 0; i < SPEC_COUNT; i++)
            reg_plan[i] = random_spec();
        reg_plan[CFG_DRIVE] = SPEC_W'({1'b1, 16'($urandom)});
        reg_plan[CFG_UNUSED] = SPEC_W'({$urandom, $urandom});
        case (kind)
            SET_EXTREME:
            begin
                reg_plan[MODE_REVERSE] = '1;
                reg_plan[MODE_COAST] = '0;
                reg_plan[CFG_DRIVE] = SPEC_W'({DRIVE_W{1'b1}});
            end
            SET_NO_WEIGHT:
                for (int i = 0; i < SPEC_COUNT; i++)
                    reg_plan[i][9:2] = '0;
            SET_NO_RANDOM:
                reg_plan[CFG_DRIVE] = '0;
            default: ;
        endcase
        write_registers();
    endtask

    task automatic run_segment(input int unsigned items, input int unsigned tx_pct,
                               input int unsigned rx_pct, input reg_set_t kind);
        int unsigned done_items;
        bit          counted;
        drain();
        plan_registers(kind);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        send_beat(FUNC_START, random_draw(), random_draw());
        done_items = 1;
        while (done_items < items)
        begin
            send_random_beat(counted);
            if (counted)
                done_items++;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset settings: commands while stopped, unused codes, a short run.
        send_beat(FUNC_TICK, 16'h0000, 16'h0000);
        send_beat(FUNC_PAUSE, 16'hFFFF, 16'hFFFF);
        send_beat(FUNC_RESUME, 16'h0000, 16'hFFFF);
        for (int k = 1; k <= 3; k++)
            send_beat(3'(FUNC_RESUME + k), 16'hFFFF, 16'hFFFF);
        send_beat(FUNC_START, 16'h0000, 16'hFFFF);
        send_beat(FUNC_PAUSE, 16'h0000, 16'h0000);
        send_beat(FUNC_TICK, 16'hFFFF, 16'h0000);
        send_beat(FUNC_RESUME, 16'h0000, 16'h0000);
        send_beat(FUNC_TICK, 16'h0000, 16'hFFFF);
        send_beat(FUNC_STOP, 16'hFFFF, 16'hFFFF);
        drain();

        // Zero weight, swapped limits, repeat rules and one disabled mode.
        reg_plan[MODE_IDLE] = make_spec(1'b1, 1'b0, 8'd0, 16'd5, 16'd5);
        reg_plan[MODE_SETTLE] = make_spec(1'b1, 1'b0, 8'd255, 16'd3, 16'd1);
        reg_plan[MODE_CENTER] = make_spec(1'b1, 1'b1, 8'd1, 16'd0, 16'd0);
        reg_plan[MODE_COAST] = make_spec(1'b0, 1'b1, 8'd200, 16'd0, 16'd0);
        reg_plan[MODE_BRAKE] = make_spec(1'b1, 1'b1, 8'd2, 16'd0, 16'd0);
        reg_plan[MODE_REVERSE] = make_spec(1'b1, 1'b0, 8'd3, 16'd0, 16'd0);
        reg_plan[CFG_DRIVE] = SPEC_W'({1'b1, 8'h00, 8'hFF});
        reg_plan[CFG_UNUSED] = '1;
        write_registers();
        send_beat(FUNC_START, 16'hFFFF, 16'h0000);
        send_beat(FUNC_TICK, 16'h0000, 16'hFFFF);
        send_beat(FUNC_TICK, 16'hFFFF, 16'h0000);
        repeat (6) send_beat(FUNC_TICK, random_draw(), random_draw());
        send_beat(FUNC_PAUSE, random_draw(), random_draw());
        send_beat(FUNC_TICK, random_draw(), random_draw());
        send_beat(FUNC_RESUME, random_draw(), random_draw());
        send_beat(FUNC_STOP, random_draw(), random_draw());

        run_segment(300, 34, 51, SET_SHUFFLED);
        run_segment(300, 51, 34, SET_EXTREME);
        run_segment(250, 0, 0, SET_SHUFFLED);
        run_segment(75, 0, 0, SET_NO_WEIGHT);
        run_segment(75, 0, 0, SET_NO_RANDOM);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
